>>> sv/bst_pkg.sv
// Shared types and constants for the binary search table.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package bst_pkg;

    localparam int unsigned DATA_W   = 32;
    localparam int unsigned INDEX_W  = 10;
    localparam int unsigned SIZE_W   = 11;
    localparam int unsigned PADDR_W  = 3;

    // Input item kinds carried on s_tuser.
    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_SEARCH = 1'b1;

    // Register index decoded from paddr[2].
    localparam logic REG_TABLE_SIZE = 1'b0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic start;
        logic step;
        logic hit_done;
        logic miss_done;
        logic push;
    } cmd_t;

    typedef struct packed {
        logic start_active;
        logic step_active;
        logic hit;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

>>> sv/bst_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; no package needed.
`default_nettype none

module bst_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  wire logic                                    clk,
    input  wire logic                                    wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                        wr_data,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

>>> sv/bst_ctrl.sv
// Controller state machine: item acceptance, probe loop sequencing, result hand-off.
// Depends on bst_pkg for the state, command and status types.
`default_nettype none

module bst_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic             func,
    input  wire bst_pkg::status_t status,
    output logic                  in_ready,
    output bst_pkg::cmd_t         cmd
);
    import bst_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (func == FUNC_SEARCH)
                    begin
                        cmd.start = 1'b1;
                        if (status.start_active)
                        begin
                            state_next = ST_PROBE;
                        end
                        else
                        begin
                            // Empty table: nothing to probe.
                            cmd.miss_done = 1'b1;
                            state_next    = ST_DONE;
                        end
                    end
                    else
                    begin
                        cmd.load = 1'b1;
                    end
                end
            end
            ST_PROBE:
            begin
                if (status.hit)
                begin
                    cmd.hit_done = 1'b1;
                    state_next   = ST_DONE;
                end
                else
                begin
                    cmd.step = 1'b1;
                    if (!status.step_active)
                    begin
                        cmd.miss_done = 1'b1;
                        state_next    = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> sv/bst_dp.sv
// Datapath: table RAM, search bounds, key compare and the output register.
// Depends on bst_pkg and bst_ram; driven by bst_ctrl through cmd_t/status_t.
`default_nettype none

module bst_dp #(
    parameter int unsigned DEPTH = 1024
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire bst_pkg::cmd_t                cmd,
    input  wire logic [bst_pkg::SIZE_W-1:0]   table_size,
    input  wire logic [bst_pkg::INDEX_W-1:0]  entry_index,
    input  wire logic [bst_pkg::DATA_W-1:0]   entry_value,
    input  wire logic [bst_pkg::DATA_W-1:0]   search_key,
    input  wire logic                         out_ready,
    output bst_pkg::status_t                  status,
    output logic                              out_valid,
    output logic                              found,
    output logic [bst_pkg::INDEX_W-1:0]       found_index
);
    import bst_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned SW = $clog2(DEPTH + 1);
    localparam logic [31:0] DEPTH_W = 32'(DEPTH);

    logic [DATA_W-1:0]  key_reg;
    logic [SW-1:0]      low_reg;
    logic [SW-1:0]      hi_reg;      // one past the last candidate
    logic [SW-1:0]      mid_reg;
    logic               res_found_reg;
    logic [INDEX_W-1:0] res_idx_reg;
    logic               out_valid_reg;
    logic               out_found_reg;
    logic [INDEX_W-1:0] out_idx_reg;

    logic [SW-1:0]      size_clamped;
    logic [SW-1:0]      low_step;
    logic [SW-1:0]      hi_step;
    logic [SW-1:0]      low_next;
    logic [SW-1:0]      hi_next;
    logic [SW:0]        mid_sum;
    logic [SW-1:0]      mid_next;
    logic [DATA_W-1:0]  rd_data;
    logic               probe_gt;
    logic               wr_en;
    logic [AW+INDEX_W-1:0] wr_addr_ext;
    logic [SW+INDEX_W-1:0] mid_ext;

    always_comb
    begin
        if (32'(table_size) > DEPTH_W)
        begin
            size_clamped = SW'(DEPTH_W);
        end
        else
        begin
            size_clamped = SW'(32'(table_size));
        end
    end

    assign probe_gt = $signed(rd_data) > $signed(key_reg);

    always_comb
    begin
        low_step = low_reg;
        hi_step  = hi_reg;
        if (probe_gt)
        begin
            hi_step = mid_reg;
        end
        else
        begin
            low_step = mid_reg + SW'(1);
        end
    end

    always_comb
    begin
        low_next = low_reg;
        hi_next  = hi_reg;
        if (cmd.start)
        begin
            low_next = '0;
            hi_next  = size_clamped;
        end
        else if (cmd.step)
        begin
            low_next = low_step;
            hi_next  = hi_step;
        end
    end

    // Midpoint of low and the inclusive upper bound; only used while low < hi.
    assign mid_sum  = {1'b0, low_next} + {1'b0, hi_next} - (SW + 1)'(1);
    assign mid_next = mid_sum[SW:1];

    assign status.start_active = (size_clamped != '0);
    assign status.step_active  = (low_step < hi_step);
    assign status.hit          = (rd_data == key_reg);
    assign status.out_free     = !out_valid_reg || out_ready;

    assign wr_en       = cmd.load && (32'(entry_index) < DEPTH_W);
    assign wr_addr_ext = {{AW{1'b0}}, entry_index};
    assign mid_ext     = {{INDEX_W{1'b0}}, mid_reg};

    bst_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr_ext[AW-1:0]),
        .wr_data (entry_value),
        .rd_addr (mid_next[AW-1:0]),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            key_reg <= search_key;
        end
        if (cmd.start || cmd.step)
        begin
            low_reg <= low_next;
            hi_reg  <= hi_next;
            mid_reg <= mid_next;
        end
        if (cmd.hit_done)
        begin
            res_found_reg <= 1'b1;
            res_idx_reg   <= mid_ext[INDEX_W-1:0];
        end
        else if (cmd.miss_done)
        begin
            res_found_reg <= 1'b0;
            res_idx_reg   <= '0;
        end
        if (cmd.push)
        begin
            out_found_reg <= res_found_reg;
            out_idx_reg   <= res_idx_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign found       = out_found_reg;
    assign found_index = out_idx_reg;

endmodule

`default_nettype wire

>>> sv/binary_search_table.sv
// Binary search table: software loads up to DEPTH signed 32-bit entries in ascending
// order through load transfers, sets table_size over APB, and sends search transfers.
// A load produces no result. A search makes p probes, where p is at most
// floor(log2(table_size)) + 1 (11 for 1024 entries); no new item is accepted until
// its result has moved to the output register. The probe loop issues one RAM read per
// cycle and that single read port sets the rate. A finished result sits in the output
// register while the next item is accepted. Each search returns found and the index
// of the first matching probe (0 when not found). Entries that were never loaded read
// as unknown values. No clearing pass is needed after reset.
// Depends on bst_pkg, bst_ctrl, bst_dp and bst_ram.
`default_nettype none

module binary_search_table #(
    parameter int unsigned DEPTH = 1024
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // Input stream
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [79:0]                   s_tdata,  // entry_index[9:0], entry_value[41:10],
                                                         // search_key[73:42], zero pad
    input  wire logic                          s_tuser,  // func
    // Result stream
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [15:0]                        m_tdata,  // found_index[9:0], zero pad
    output logic                               m_tuser,  // found
    // APB configuration
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [bst_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import bst_pkg::*;

    logic [SIZE_W-1:0]  table_size_reg;
    cmd_t               cmd;
    status_t            status;
    logic [INDEX_W-1:0] found_index;
    logic               reg_wr;
    logic               reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign reg_wr  = psel && penable && pwrite && (reg_sel == REG_TABLE_SIZE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg <= '0;
        end
        else if (reg_wr)
        begin
            table_size_reg <= pwdata[SIZE_W-1:0];
        end
    end

    always_comb
    begin
        if (reg_sel == REG_TABLE_SIZE)
        begin
            prdata = {{(32 - SIZE_W){1'b0}}, table_size_reg};
        end
        else
        begin
            prdata = '0;
        end
    end

    bst_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .func     (s_tuser),
        .status   (status),
        .in_ready (s_tready),
        .cmd      (cmd)
    );

    bst_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .table_size  (table_size_reg),
        .entry_index (s_tdata[9:0]),
        .entry_value (s_tdata[41:10]),
        .search_key  (s_tdata[73:42]),
        .out_ready   (m_tready),
        .status      (status),
        .out_valid   (m_tvalid),
        .found       (m_tuser),
        .found_index (found_index)
    );

    assign m_tdata = {6'b0, found_index};

endmodule

`default_nettype wire

>>> sv/bst_checker.sv
// Port-level checks for binary_search_table, bound to every instance of it.
// Depends on bst_pkg for the item kind codes.
`default_nettype none

module bst_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic        s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [15:0] m_tdata,
    input  wire logic        m_tuser,
    input  wire logic        psel,
    input  wire logic        pready
);
    import bst_pkg::*;

    // A result held back by the sink must not change.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // A miss always reports index zero.
    a_miss_index: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata == 16'd0)
        else $error("miss with nonzero index");

    // A search occupies the block for at least the following cycle.
    a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == FUNC_SEARCH) |=> !s_tready)
        else $error("input accepted right after a search");

    // The configuration port never inserts wait states.
    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        psel |-> pready)
        else $error("pready low");

endmodule

bind binary_search_table bst_checker u_bst_checker (.*);

`default_nettype wire
